// ===== rtl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types, constants and helpers for the priority message queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmq_pkg;

  // Storage geometry
  localparam int DEPTH     = 16;
  localparam int MAX_BYTES = 8;
  localparam int AW        = $clog2(DEPTH);      // ring address
  localparam int CW        = $clog2(DEPTH + 1);  // message count

  // Field widths
  localparam int OP_W   = 2;
  localparam int PRIO_W = 32;
  localparam int LEN_W  = 4;
  localparam int PAY_W  = 64;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 5;

  // Config port
  localparam int CAP_W  = 5;
  localparam int SIZE_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CMP_W   = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_SIZE     = 1'b1
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_SEND  = 2'd0,
    OP_RECV  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_SMALL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_DEQ_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CW-1:0]     eff_cap;
    logic [SIZE_W-1:0] eff_size;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
    logic [PRIO_W-1:0] prio;
    logic [CW-1:0]     occ;
  } res_t;

  // Keep only the low n bytes.
  function automatic logic [PAY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [PAY_W-1:0] m;
    m = '0;
    for (int i = 0; i < PAY_W / 8; i++) begin
      m[8*i +: 8] = (LEN_W'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Address arithmetic modulo DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

// ===== rtl/priority_message_queue.sv =====
// ----------------------------------------------------------------------------
// priority_message_queue
// Throughput: a new request is taken only after the last word has gone into the
//   output register; a send walks the ring one entry per cycle through the
//   single memory read port and priority comparator.
// Reset (synchronous, rst_n low): queue empty, limits 16 and 8, no output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_message_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pmq_pkg::OP_W-1:0]    in_operation,
  input  logic [pmq_pkg::PRIO_W-1:0]  in_priority_req,
  input  logic [pmq_pkg::LEN_W-1:0]   in_length,
  input  logic [pmq_pkg::PAY_W-1:0]   in_payload,
  input  logic [pmq_pkg::LEN_W-1:0]   in_buffer_room,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pmq_pkg::STAT_W-1:0]  out_status,
  output logic [pmq_pkg::LEN_W-1:0]   out_length_out,
  output logic [pmq_pkg::PAY_W-1:0]   out_payload_out,
  output logic [pmq_pkg::PRIO_W-1:0]  out_priority_out,
  output logic [pmq_pkg::OCC_W-1:0]   out_occupancy,
  // config port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pmq_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [pmq_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [pmq_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  // Storage is a ring: head_r points at the highest-priority entry, and the
  // entries follow in service order. A send walks back from the tail, moving
  // each lower-priority entry up by one slot, then drops the new word into
  // the gap. Equal priorities stop the walk, so same-priority words stay FIFO.

  pmq_pkg::cfg_t     cfg;
  pmq_pkg::mem_req_t req;
  pmq_pkg::entry_t   rd_data;
  pmq_pkg::res_t     res;
  logic              res_valid;
  logic              out_free;

  logic                        out_valid_r;
  logic [pmq_pkg::STAT_W-1:0]  out_status_r;
  logic [pmq_pkg::LEN_W-1:0]   out_len_r;
  logic [pmq_pkg::PAY_W-1:0]   out_pay_r;
  logic [pmq_pkg::PRIO_W-1:0]  out_prio_r;
  logic [pmq_pkg::OCC_W-1:0]   out_occ_r;

  pmq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pmq_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  pmq_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_priority_req (in_priority_req),
    .in_length       (in_length),
    .in_payload      (in_payload),
    .in_buffer_room  (in_buffer_room),
    .cfg             (cfg),
    .out_free        (out_free),
    .res_valid       (res_valid),
    .res             (res),
    .req             (req),
    .rd_data         (rd_data)
  );

  // Output register: the sequencer keeps going on the next word while this
  // one waits; it only parks in its response state if the slot is still full.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status_r <= res.status;
      out_len_r    <= res.len;
      out_pay_r    <= res.pay;
      out_prio_r   <= res.prio;
      out_occ_r    <= pmq_pkg::OCC_W'(res.occ);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_length_out   = out_len_r;
  assign out_payload_out  = out_pay_r;
  assign out_priority_out = out_prio_r;
  assign out_occupancy    = out_occ_r;

`ifndef SYNTH
  // occupancy can never pass the storage depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= pmq_pkg::OCC_W'(pmq_pkg::DEPTH)))
    else $error("occupancy above depth");

  // a failed word carries no message
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != pmq_pkg::ST_OK)) |->
      ((out_length_out == '0) && (out_payload_out == '0) && (out_priority_out == '0)))
    else $error("failed word with message fields");

  // dequeued bytes stay within the stated length
  a_len_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_length_out <= pmq_pkg::LEN_W'(pmq_pkg::MAX_BYTES)) &&
      ((out_payload_out & ~pmq_pkg::byte_mask(out_length_out)) == '0)))
    else $error("payload bytes beyond length");
`endif

endmodule

// ===== rtl/pmq_cfg.sv =====
// ----------------------------------------------------------------------------
// pmq_cfg
// APB-style register file: capacity and size limits, clamped for use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmq_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pmq_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [pmq_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [pmq_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output pmq_pkg::cfg_t                cfg
);

  logic [pmq_pkg::CAP_W-1:0]  cap_r;
  logic [pmq_pkg::SIZE_W-1:0] size_r;
  logic                       wr_en;
  pmq_pkg::reg_idx_t          idx;
  logic [pmq_pkg::CMP_W-1:0]  cap_w;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = pmq_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= pmq_pkg::CAP_RESET;
      size_r <= pmq_pkg::SIZE_RESET;
    end else if (wr_en) begin
      case (idx)
        pmq_pkg::REG_CAPACITY: cap_r  <= cfg_pwdata[pmq_pkg::CAP_W-1:0];
        pmq_pkg::REG_SIZE:     size_r <= cfg_pwdata[pmq_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pmq_pkg::REG_CAPACITY: cfg_prdata = pmq_pkg::PDATA_W'(cap_r);
      pmq_pkg::REG_SIZE:     cfg_prdata = pmq_pkg::PDATA_W'(size_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // Clamp to what the storage can actually hold
  assign cap_w = pmq_pkg::CMP_W'(cap_r);
  assign cfg.eff_cap = (cap_w > pmq_pkg::CMP_W'(pmq_pkg::DEPTH))
                     ? pmq_pkg::CW'(pmq_pkg::DEPTH) : pmq_pkg::CW'(cap_w);
  assign cfg.eff_size = (size_r > pmq_pkg::SIZE_W'(pmq_pkg::MAX_BYTES))
                      ? pmq_pkg::SIZE_W'(pmq_pkg::MAX_BYTES) : size_r;

endmodule

// ===== rtl/pmq_mem.sv =====
// ----------------------------------------------------------------------------
// pmq_mem
// Message store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmq_mem (
  input  logic              clk,
  input  pmq_pkg::mem_req_t req,
  output pmq_pkg::entry_t   rd_data
);

  pmq_pkg::entry_t mem_q [pmq_pkg::DEPTH];
  pmq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_q[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/pmq_seq.sv =====
// ----------------------------------------------------------------------------
// pmq_seq
// Sequencer: ordered insert by walking back from the tail with one
// priority comparator, head dequeue, clear, and result staging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmq_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pmq_pkg::OP_W-1:0]    in_operation,
  input  logic [pmq_pkg::PRIO_W-1:0]  in_priority_req,
  input  logic [pmq_pkg::LEN_W-1:0]   in_length,
  input  logic [pmq_pkg::PAY_W-1:0]   in_payload,
  input  logic [pmq_pkg::LEN_W-1:0]   in_buffer_room,
  input  pmq_pkg::cfg_t               cfg,
  input  logic                        out_free,
  output logic                        res_valid,
  output pmq_pkg::res_t               res,
  output pmq_pkg::mem_req_t           req,
  input  pmq_pkg::entry_t             rd_data
);

  pmq_pkg::state_t                state_r, state_nxt;
  logic [pmq_pkg::CW-1:0]         count_r, count_nxt;
  logic [pmq_pkg::AW-1:0]         head_r, head_nxt;
  logic [pmq_pkg::CW-1:0]         idx_r, idx_nxt;
  pmq_pkg::entry_t                item_r, item_nxt;
  logic [pmq_pkg::LEN_W-1:0]      room_r, room_nxt;
  pmq_pkg::res_t                  res_r, res_nxt;
  pmq_pkg::entry_t                new_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmq_pkg::S_IDLE;
      count_r <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    item_r <= item_nxt;
    room_r <= room_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    new_entry.prio = in_priority_req;
    new_entry.len  = in_length;
    new_entry.pay  = in_payload & pmq_pkg::byte_mask(in_length);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    item_nxt  = item_r;
    room_nxt  = room_r;
    res_nxt   = res_r;
    req       = '0;
    in_ready  = (state_r == pmq_pkg::S_IDLE);
    res_valid = 1'b0;
    res       = res_r;
    res.occ   = count_r;

    case (state_r)
      pmq_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt       = new_entry;
          room_nxt       = in_buffer_room;
          res_nxt        = '0;
          res_nxt.status = pmq_pkg::ST_OK;
          state_nxt      = pmq_pkg::S_RESP;
          case (in_operation)
            pmq_pkg::OP_SEND: begin
              if (in_length > cfg.eff_size) begin
                res_nxt.status = pmq_pkg::ST_TOO_LONG;
              end else if (count_r >= cfg.eff_cap) begin
                res_nxt.status = pmq_pkg::ST_FULL;
              end else if (count_r == '0) begin
                req.we    = 1'b1;
                req.waddr = head_r;
                req.wdata = new_entry;
                count_nxt = count_r + pmq_pkg::CW'(1);
              end else begin
                // start the walk at the tail entry
                idx_nxt   = count_r;
                req.re    = 1'b1;
                req.raddr = pmq_pkg::ring_add(head_r,
                              pmq_pkg::AW'(count_r - pmq_pkg::CW'(1)));
                state_nxt = pmq_pkg::S_INS_CMP;
              end
            end
            pmq_pkg::OP_RECV: begin
              if (count_r == '0) begin
                res_nxt.status = pmq_pkg::ST_EMPTY;
              end else begin
                req.re    = 1'b1;
                req.raddr = head_r;
                state_nxt = pmq_pkg::S_DEQ_CHK;
              end
            end
            pmq_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // rd_data holds entry idx_r-1; strict compare keeps equal priorities FIFO
      pmq_pkg::S_INS_CMP: begin
        req.we = 1'b1;
        if (item_r.prio > rd_data.prio) begin
          req.waddr = pmq_pkg::ring_add(head_r, idx_r[pmq_pkg::AW-1:0]);
          req.wdata = rd_data;
          idx_nxt   = idx_r - pmq_pkg::CW'(1);
          if (idx_r == pmq_pkg::CW'(1)) begin
            state_nxt = pmq_pkg::S_INS_PUT;
          end else begin
            req.re    = 1'b1;
            req.raddr = pmq_pkg::ring_add(head_r,
                          pmq_pkg::AW'(idx_r - pmq_pkg::CW'(2)));
          end
        end else begin
          req.waddr = pmq_pkg::ring_add(head_r, idx_r[pmq_pkg::AW-1:0]);
          req.wdata = item_r;
          count_nxt = count_r + pmq_pkg::CW'(1);
          state_nxt = pmq_pkg::S_RESP;
        end
      end

      pmq_pkg::S_INS_PUT: begin
        req.we    = 1'b1;
        req.waddr = head_r;
        req.wdata = item_r;
        count_nxt = count_r + pmq_pkg::CW'(1);
        state_nxt = pmq_pkg::S_RESP;
      end

      pmq_pkg::S_DEQ_CHK: begin
        if (rd_data.len > room_r) begin
          res_nxt.status = pmq_pkg::ST_SMALL;
        end else begin
          res_nxt.len  = rd_data.len;
          res_nxt.pay  = rd_data.pay & pmq_pkg::byte_mask(rd_data.len);
          res_nxt.prio = rd_data.prio;
          head_nxt     = pmq_pkg::ring_add(head_r, pmq_pkg::AW'(1));
          count_nxt    = count_r - pmq_pkg::CW'(1);
        end
        state_nxt = pmq_pkg::S_RESP;
      end

      pmq_pkg::S_RESP: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = pmq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pmq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
